@@ rtl/vt4_pkg.sv @@
package vt4_pkg;

   localparam int NUM_LANES   = 4;
   localparam int NUM_CFG     = 8;
   localparam int CFG_W       = 64;
   localparam int CFG_SEL_W   = $clog2(NUM_CFG);
   localparam int CSR_INDEX_W = 4;
   localparam int COMP_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = 2 * COMP_W;
   localparam int PAIR_W      = PROD_W + 1;
   localparam int SUM_W       = PROD_W + 2;
   localparam int DATA_W      = NUM_LANES * COMP_W;

   localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

   localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [COMP_W-1:0] SAT_MAX    = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic signed [COMP_W-1:0] SAT_MIN    = {1'b1, {(COMP_W-1){1'b0}}};

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef comp_type [NUM_LANES-1:0] vec4_type;

   typedef struct packed {
      comp_type value;
      logic     sat;
   } lane_result_type;

   typedef lane_result_type [NUM_LANES-1:0] lane_results_type;

endpackage

@@ rtl/vt4_lane.sv @@
module vt4_lane
   import vt4_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  vec4_type        coef_row,
   input  vec4_type        point,
   output lane_result_type result
);

   logic signed [PROD_W-1:0] prod_ff  [NUM_LANES];
   logic signed [PROD_W-1:0] prod_in  [NUM_LANES];
   logic signed [PAIR_W-1:0] pair_ff  [2];
   logic signed [PAIR_W-1:0] pair_in  [2];
   logic signed [SUM_W-1:0]  total_ff;
   logic signed [SUM_W-1:0]  total_in;

   // products in q32.32
   always_comb begin
      for (int c = 0; c < NUM_LANES; c++) begin
         prod_in[c] = $signed({{COMP_W{coef_row[c][COMP_W-1]}}, coef_row[c]})
                    * $signed({{COMP_W{point[c][COMP_W-1]}}, point[c]});
      end
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         pair_in[k] = $signed({prod_ff[2*k][PROD_W-1], prod_ff[2*k]})
                    + $signed({prod_ff[2*k+1][PROD_W-1], prod_ff[2*k+1]});
      end
   end

   // exact sum plus half an lsb of the result
   assign total_in = $signed({pair_ff[0][PAIR_W-1], pair_ff[0]})
                   + $signed({pair_ff[1][PAIR_W-1], pair_ff[1]})
                   + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < NUM_LANES; c++) begin
            prod_ff[c] <= prod_in[c];
         end
         for (int k = 0; k < 2; k++) begin
            pair_ff[k] <= pair_in[k];
         end
         total_ff <= total_in;
      end
   end

   // floor shift, then saturate when the upper bits are not all sign
   logic [SUM_W-FRAC_W-COMP_W:0] upper;
   logic                         fits;

   assign upper = total_ff[SUM_W-1:FRAC_W+COMP_W-1];
   assign fits  = (&upper) || !(|upper);

   always_comb begin
      result.sat = !fits;
      if (fits) begin
         result.value = total_ff[FRAC_W+COMP_W-1:FRAC_W];
      end else if (total_ff[SUM_W-1]) begin
         result.value = SAT_MIN;
      end else begin
         result.value = SAT_MAX;
      end
   end

endmodule

@@ rtl/vt4_merge.sv @@
module vt4_merge
   import vt4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  lane_results_type lanes,
   output logic             up_ready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,
   output logic [0:0]       rsp_tuser
);

   logic [DATA_W-1:0] word_in;
   logic              ovf_in;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_ovf_ff;
   logic              out_valid_ff;
   logic [DATA_W-1:0] skid_data_ff;
   logic              skid_ovf_ff;
   logic              skid_valid_ff;
   logic              push;

   // combine the four rows into one word
   always_comb begin
      ovf_in = 1'b0;
      for (int r = 0; r < NUM_LANES; r++) begin
         word_in[r*COMP_W +: COMP_W] = lanes[r].value;
         ovf_in = ovf_in | lanes[r].sat;
      end
   end

   assign up_ready = !skid_valid_ff;
   assign push     = in_valid && up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_tready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            out_ovf_ff  <= skid_ovf_ff;
         end else begin
            out_data_ff <= word_in;
            out_ovf_ff  <= ovf_in;
         end
      end else if (push) begin
         skid_data_ff <= word_in;
         skid_ovf_ff  <= ovf_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_ovf_ff;

endmodule

@@ rtl/vertex_transform_4x4_unit.sv @@
// Multiplies each homogeneous point (x, y, z, w), signed q16.16, by a 4x4
// matrix held in eight 64-bit registers (two coefficients per register, the
// lower column in bits 31:0; index 2r and 2r+1 hold row r, from 0). The
// matrix resets to identity and writes to indexes above 7 are dropped; write
// it only while no word is in flight. Each row is an exact four-term dot
// product rounded to nearest (ties up), saturated to 32 bits; overflow in
// tuser is set when any row saturated. One row lane per output component,
// each with four multipliers, so a new word is taken every cycle unless the
// skid stage is full. An accepted word passes through the product, pair sum
// and total registers and is then loaded into the output register; a skid
// stage keeps the input side running for one word while the output is stalled.
module vertex_transform_4x4_unit
   import vt4_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // in_x, in_y, in_z, in_w
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // out_x, out_y, out_z, out_w
   output logic [0:0]             rsp_tuser,   // overflow
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   localparam int PIPE_DEPTH = 3;

   logic [CFG_W-1:0]      cfg_ff [NUM_CFG];
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic                  en;
   vec4_type              point;
   lane_results_type      lanes;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) begin
            cfg_ff[i] <= CFG_RESET[i];
         end
      end else if (csr_valid && (csr_index < CSR_INDEX_W'(NUM_CFG))) begin
         cfg_ff[csr_index[CFG_SEL_W-1:0]] <= csr_data;
      end
   end

   assign req_tready = en;
   assign valid_in   = {valid_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_LANES; c++) begin
         point[c] = req_tdata[c*COMP_W +: COMP_W];
      end
   end

   for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
      vec4_type coef_row;

      assign coef_row[0] = cfg_ff[2*r][COMP_W-1:0];
      assign coef_row[1] = cfg_ff[2*r][CFG_W-1:COMP_W];
      assign coef_row[2] = cfg_ff[2*r+1][COMP_W-1:0];
      assign coef_row[3] = cfg_ff[2*r+1][CFG_W-1:COMP_W];

      vt4_lane u_lane (
         .clock    (clock),
         .en       (en),
         .coef_row (coef_row),
         .point    (point),
         .result   (lanes[r])
      );
   end

   vt4_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_ff[PIPE_DEPTH-1]),
      .lanes      (lanes),
      .up_ready   (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ verif/vt4_checker.sv @@
`timescale 1ns / 100ps

module vt4_checker
   import vt4_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // in_x, in_y, in_z, in_w
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [DATA_W-1:0]      rsp_tdata,   // out_x, out_y, out_z, out_w
   input  logic [0:0]             rsp_tuser,   // overflow
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   output int                     mismatch_total,
   output int                     pending_words
);

   localparam int ACC_W = SUM_W + 4;

   typedef struct packed {
      vec4_type point;
      logic     overflow;
   } vertex_result_type;

   logic [CFG_W-1:0]  matrix [NUM_CFG];
   vertex_result_type expected_vertices [$];
   int                errors = 0;
   string             lane_name [NUM_LANES] = '{"out_x", "out_y", "out_z", "out_w"};

   // exact dot product per row, round half up, clamp to 32 bits
   function automatic vertex_result_type transform_point(input vec4_type pt);
      vertex_result_type        res;
      logic [CFG_W-1:0]         word;
      logic signed [COMP_W-1:0] coef;
      logic signed [COMP_W-1:0] comp;
      logic signed [ACC_W-1:0]  acc;
      res.overflow = 1'b0;
      for (int row = 0; row < NUM_LANES; row++) begin
         acc = '0;
         for (int col = 0; col < NUM_LANES; col++) begin
            word = matrix[2 * row + col / 2];
            coef = (col % 2 == 1) ? word[2*COMP_W-1:COMP_W] : word[COMP_W-1:0];
            comp = pt[col];
            acc  = acc + coef * comp;
         end
         acc = (acc + ROUND_HALF) >>> FRAC_W;
         if (acc > SAT_MAX) begin
            res.point[row] = SAT_MAX;
            res.overflow   = 1'b1;
         end else if (acc < SAT_MIN) begin
            res.point[row] = SAT_MIN;
            res.overflow   = 1'b1;
         end else begin
            res.point[row] = acc[COMP_W-1:0];
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what, input logic [COMP_W-1:0] want,
                                input logic [COMP_W-1:0] got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      vertex_result_type want;
      vec4_type          got;
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++)
            matrix[i] = CFG_RESET[i];
         expected_vertices.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < NUM_CFG)
            matrix[csr_index[CFG_SEL_W-1:0]] = csr_data;
         if (req_tvalid && req_tready)
            expected_vertices.push_back(transform_point(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_vertices.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result word %h with no point pending", $time, got);
            end else begin
               want = expected_vertices.pop_front();
               for (int lane = 0; lane < NUM_LANES; lane++)
                  if (got[lane] !== want.point[lane])
                     note_mismatch(lane_name[lane], want.point[lane], got[lane]);
               if (rsp_tuser[0] !== want.overflow)
                  note_mismatch("overflow", COMP_W'(want.overflow), COMP_W'(rsp_tuser[0]));
            end
         end
      end
      mismatch_total <= errors;
      pending_words  <= expected_vertices.size();
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import vt4_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 220;
   localparam int RANDOM_PHASES = 8;
   localparam logic signed [COMP_W-1:0] ONE  = 32'sh0001_0000;
   localparam logic signed [COMP_W-1:0] HALF = 32'sh0000_8000;

   typedef enum int {
      COEF_FULL,
      COEF_SMALL,
      COEF_EXTREME,
      COEF_SPARSE,
      COEF_IDENTITY
   } coef_kind_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]       csr_data   = '0;

   logic [CFG_W-1:0] next_matrix [NUM_CFG];
   int               hold_requests = 0;
   bit               tx_steady     = 1'b0;
   int               mismatch_total;
   int               pending_words;

   vertex_transform_4x4_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   vt4_checker vertex_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_total (mismatch_total),
      .pending_words  (pending_words)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 85)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic comp_type pick_extreme();
      case ($urandom_range(0, 6))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return '0;
         3: return ONE;
         4: return -ONE;
         5: return HALF;
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic comp_type random_coef(input coef_kind_type kind);
      case (kind)
         COEF_SMALL:   return comp_type'($urandom_range(0, 2**19 - 1)) - 2**18;
         COEF_EXTREME: return pick_extreme();
         COEF_SPARSE:  return ($urandom_range(0, 1) == 0) ? '0 : random_coef(COEF_SMALL);
         default:      return comp_type'($urandom);
      endcase
   endfunction

   function automatic comp_type random_comp();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return comp_type'($urandom);
         4, 5, 6:    return comp_type'($urandom_range(0, 2**25 - 1)) - 2**24;
         7:          return pick_extreme();
         default:    return comp_type'($urandom_range(0, 255)) - 128;
      endcase
   endfunction

   function automatic vec4_type pt4(input comp_type x, input comp_type y,
                                    input comp_type z, input comp_type w);
      vec4_type v;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      v[3] = w;
      return v;
   endfunction

   function automatic vec4_type random_point();
      return pt4(random_comp(), random_comp(), random_comp(), random_comp());
   endfunction

   function automatic void set_coef(input int row, input int col, input comp_type value);
      next_matrix[2 * row + col / 2][COMP_W * (col % 2) +: COMP_W] = value;
   endfunction

   function automatic void fill_diag(input comp_type off_diag, input comp_type diag);
      for (int row = 0; row < NUM_LANES; row++)
         for (int col = 0; col < NUM_LANES; col++)
            set_coef(row, col, (row == col) ? diag : off_diag);
   endfunction

   // all eight words back to back, optionally one write to an unused index
   task automatic load_matrix(input bit add_stray);
      int writes;
      writes = add_stray ? NUM_CFG + 1 : NUM_CFG;
      for (int i = 0; i < writes; i++) begin
         csr_valid <= 1'b1;
         if (i < NUM_CFG) begin
            csr_index <= CSR_INDEX_W'(i);
            csr_data  <= next_matrix[i];
         end else begin
            csr_index <= CSR_INDEX_W'($urandom_range(NUM_CFG, 2**CSR_INDEX_W - 1));
            csr_data  <= {$urandom, $urandom};
         end
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_point(input vec4_type pt, input bit is_last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= pt;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      gap = tx_steady ? 0 : idle_gap();
      if (gap > 0 || is_last)
         req_tvalid <= 1'b0;
      repeat (gap)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_words != 0)
         @(posedge clock);
   endtask

   // result side: random stalls, quiet stretches, long hold-offs on request
   initial begin
      int stall_left;
      int served;
      int cycle_count;
      bit steady;
      stall_left  = 0;
      served      = 0;
      cycle_count = 0;
      steady      = 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count % 128 == 0)
            steady = ($urandom_range(0, 3) == 0);
         if (served != hold_requests) begin
            served     = hold_requests;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = steady ? 0 : idle_gap();
         end
      end
   end

   initial begin
      coef_kind_type kind;
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;

      // identity from reset
      send_point(pt4('0, '0, '0, '0), 1'b0);
      send_point(pt4(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b0);
      send_point(pt4(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b0);
      send_point(pt4(ONE, -ONE, 32'sd1, -32'sd1), 1'b0);
      send_point(random_point(), 1'b1);
      wait_drained();

      // exact ties round toward plus infinity
      fill_diag('0, HALF);
      load_matrix(1'b0);
      send_point(pt4(32'sd1, -32'sd1, 32'sd3, -32'sd3), 1'b0);
      send_point(pt4(SAT_MAX, SAT_MIN, 32'sd5, -32'sd5), 1'b1);
      wait_drained();

      // rounding carries past the top or lands exactly on the bottom
      fill_diag('0, ONE);
      set_coef(0, 1, HALF);
      load_matrix(1'b1);
      send_point(pt4(SAT_MAX, 32'sd1, SAT_MAX, SAT_MIN), 1'b0);
      send_point(pt4(SAT_MIN, -32'sd1, '0, '0), 1'b0);
      send_point(pt4(SAT_MIN, -32'sd2, ONE, -ONE), 1'b1);
      wait_drained();

      fill_diag(SAT_MAX, SAT_MAX);
      load_matrix(1'b0);
      send_point(pt4(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b0);
      send_point(pt4(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b0);
      send_point(pt4(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN), 1'b1);
      wait_drained();

      fill_diag(SAT_MIN, SAT_MIN);
      load_matrix(1'b1);
      send_point(pt4(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b0);
      send_point(pt4(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b0);
      send_point(pt4(ONE, -ONE, '0, 32'sd1), 1'b1);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         kind = coef_kind_type'(phase % 5);
         if (kind == COEF_IDENTITY)
            fill_diag('0, ONE);
         else
            for (int row = 0; row < NUM_LANES; row++)
               for (int col = 0; col < NUM_LANES; col++)
                  set_coef(row, col, random_coef(kind));
         load_matrix(phase % 2 == 0);
         tx_steady = (phase % 3 == 1);
         if (phase == 2)
            hold_requests <= hold_requests + 1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_point(random_point(), n == PHASE_ITEMS - 1);
         wait_drained();
      end

      repeat (20)
         @(posedge clock);
      if (mismatch_total == 0 && pending_words == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/vt4_pkg.sv
rtl/vt4_lane.sv
rtl/vt4_merge.sv
rtl/vertex_transform_4x4_unit.sv
verif/vt4_checker.sv
verif/testbench.sv
